// File: rtl/breathing_pwm_three_channel_unit_defines.svh
// Assertion macros used by the top RTL file of the breathing PWM unit.
`ifndef BREATHING_PWM_THREE_CHANNEL_UNIT_DEFINES_SVH
`define BREATHING_PWM_THREE_CHANNEL_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPWM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpwm same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpwm next-cycle check failed");

`endif

// File: rtl/bpwm_pkg.sv
package bpwm_pkg;

   // Command codes carried in req_tuser.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_DUTY  = 2'd1,
      OP_PULSE = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_AUTO_RELOAD = 2'd0;
   localparam logic [1:0] CSR_RAMP_LOW    = 2'd1;
   localparam logic [1:0] CSR_RAMP_HIGH   = 2'd2;

   localparam int CSR_W       = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_W-1:0] AUTO_RELOAD_RESET = 16'd4079;
   localparam logic [CSR_W-1:0] RAMP_LOW_RESET    = 16'd2;
   localparam logic [CSR_W-1:0] RAMP_HIGH_RESET   = 16'd3818;

   localparam int DUTY_W   = 8;
   localparam int PERIOD_W = 8;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;

   // Per-channel command, already decoded and steered to one channel.
   typedef struct packed {
      logic              tick;
      logic              set_duty;
      logic              set_pulse;
      logic              pulse_on;
      logic [DUTY_W-1:0] duty;
   } cmd_type;

endpackage

// File: rtl/bpwm_counter.sv
module bpwm_counter #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       tick,
   input  logic [bpwm_pkg::CSR_W-1:0] auto_reload,
   output logic [COUNTER_WIDTH-1:0]   count_q,
   output logic [COUNTER_WIDTH-1:0]   count_next,
   output logic                       wrap
);
   import bpwm_pkg::*;

   logic [COUNTER_WIDTH-1:0] count_ff;
   logic [COUNTER_WIDTH-1:0] count_in;
   logic [COUNTER_WIDTH-1:0] top_value;
   logic                     at_top;

   // A counter left above a lowered top wraps on the next tick.
   assign top_value = COUNTER_WIDTH'(auto_reload);
   assign at_top    = (count_ff >= top_value);

   always_comb begin
      count_in = count_ff;
      if (tick) begin
         count_in = at_top ? '0 : count_ff + COUNTER_WIDTH'(1);
      end
   end

   assign wrap       = tick && at_top;
   assign count_next = count_in;
   assign count_q    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/bpwm_channel.sv
module bpwm_channel #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  bpwm_pkg::cmd_type          cmd,
   input  logic [COUNTER_WIDTH-1:0]   count,
   input  logic [bpwm_pkg::CSR_W-1:0] ramp_low,
   input  logic [bpwm_pkg::CSR_W-1:0] ramp_high,
   output logic                       level
);
   import bpwm_pkg::*;

   localparam int CMP_W = (COUNTER_WIDTH > CSR_W) ? COUNTER_WIDTH : CSR_W;

   logic [COUNTER_WIDTH-1:0] compare_ff;
   logic [COUNTER_WIDTH-1:0] compare_in;
   logic                     dir_up_ff;
   logic                     dir_up_in;
   logic                     breathe_ff;
   logic                     breathe_in;

   always_comb begin
      compare_in = compare_ff;
      dir_up_in  = dir_up_ff;
      breathe_in = breathe_ff;
      if (cmd.tick) begin
         // A match on the new count steps the ramp by one, saturating at both ends.
         if (breathe_ff && (compare_ff == count)) begin
            if (CMP_W'(compare_ff) < CMP_W'(ramp_low)) begin
               dir_up_in = 1'b1;
            end else if (CMP_W'(compare_ff) > CMP_W'(ramp_high)) begin
               dir_up_in = 1'b0;
            end
            if (dir_up_in) begin
               if (compare_ff != '1) begin
                  compare_in = compare_ff + COUNTER_WIDTH'(1);
               end
            end else begin
               if (compare_ff != '0) begin
                  compare_in = compare_ff - COUNTER_WIDTH'(1);
               end
            end
         end
      end else if (cmd.set_duty) begin
         compare_in = COUNTER_WIDTH'({cmd.duty, 4'b0000});
      end else if (cmd.set_pulse) begin
         if (cmd.pulse_on) begin
            compare_in = '0;
            breathe_in = 1'b1;
         end else begin
            breathe_in = 1'b0;
         end
      end
   end

   assign level = (count < compare_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_ff <= '0;
         dir_up_ff  <= 1'b1;
         breathe_ff <= 1'b0;
      end else if (accept) begin
         compare_ff <= compare_in;
         dir_up_ff  <= dir_up_in;
         breathe_ff <= breathe_in;
      end
   end

endmodule

// File: rtl/breathing_pwm_three_channel_unit.sv
// Three-channel edge-aligned PWM with an optional breathing ramp per channel.
// Commands arrive on the req_ stream: every transaction is one tick of the shared
// up counter, a set-duty command, a breathing-pulse command or a no-operation.
// Each accepted transaction produces exactly one transaction on the rsp_ stream
// carrying the three channel levels and a flag for a counter wrap on that tick.
// All state updates for a transaction happen in the cycle it is accepted, and its
// result is registered, so the result appears in the cycle after acceptance and a
// new request can be taken in every cycle unless a result is held: throughput is
// one transaction per clock, set by the single compare/step path of each channel.
// The result register acts as the only buffer: while rsp_tvalid is high and the
// receiver holds rsp_tready low, req_tready is low and no request is taken; the
// held result stays unchanged until it is taken.
// The csr_ port writes one of auto_reload, ramp_low and ramp_high per write;
// writes should only be made while no request is in flight.
// Synchronous reset clears the counter and all compare values, turns breathing
// off, points every ramp upward, restores the register defaults (4079, 2, 3818)
// and empties the result register.
`include "breathing_pwm_three_channel_unit_defines.svh"

module breathing_pwm_three_channel_unit #(
   parameter int CHANNEL_COUNT = 3,
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: channel [1:0], duty_value [9:2], pulse_period [17:10], zero [23:18]
   input  logic [bpwm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: op [1:0]
   input  logic [bpwm_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rsp_tdata: pwm_level_a [0], pwm_level_b [1], pwm_level_c [2], period_wrap [3],
   // zero [7:4]
   output logic [bpwm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [bpwm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpwm_pkg::CSR_W-1:0]       csr_wdata
);
   import bpwm_pkg::*;

   // Configuration registers.
   logic [CSR_W-1:0] auto_reload_ff;
   logic [CSR_W-1:0] ramp_low_ff;
   logic [CSR_W-1:0] ramp_high_ff;

   // Result register: bit 3 is the wrap flag, bits 2:0 the channel levels.
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [3:0] rsp_data_ff;
   logic [3:0] rsp_data_in;

   logic                accept;
   op_type              op;
   logic [1:0]          channel;
   logic [DUTY_W-1:0]   duty_value;
   logic [PERIOD_W-1:0] pulse_period;
   logic                is_tick;

   logic [COUNTER_WIDTH-1:0] count_q;
   logic [COUNTER_WIDTH-1:0] count_next;
   logic                     counter_wrap;
   logic [CHANNEL_COUNT-1:0] levels;
   logic [2:0]               levels_out;

   // Field unpacking.
   assign op           = op_type'(req_tuser);
   assign channel      = req_tdata[1:0];
   assign duty_value   = req_tdata[9:2];
   assign pulse_period = req_tdata[17:10];
   assign is_tick      = (op == OP_TICK);

   // A request is taken whenever the result register is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_reload_ff <= AUTO_RELOAD_RESET;
         ramp_low_ff    <= RAMP_LOW_RESET;
         ramp_high_ff   <= RAMP_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AUTO_RELOAD: auto_reload_ff <= csr_wdata;
            CSR_RAMP_LOW:    ramp_low_ff    <= csr_wdata;
            CSR_RAMP_HIGH:   ramp_high_ff   <= csr_wdata;
            default: begin
               // Writes to indexes beyond the register list are dropped.
            end
         endcase
      end
   end

   bpwm_counter #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_counter (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .tick        (is_tick),
      .auto_reload (auto_reload_ff),
      .count_q     (count_q),
      .count_next  (count_next),
      .wrap        (counter_wrap)
   );

   // One channel slice per output; commands for a channel that does not exist
   // never match any slice and are dropped.
   for (genvar gi = 0; gi < CHANNEL_COUNT; gi++) begin : g_channel
      cmd_type cmd;
      logic    selected;

      assign selected = (32'(channel) == gi);

      always_comb begin
         cmd           = '0;
         cmd.duty      = duty_value;
         cmd.pulse_on  = (pulse_period != '0);
         case (op)
            OP_TICK:  cmd.tick      = 1'b1;
            OP_DUTY:  cmd.set_duty  = selected;
            OP_PULSE: cmd.set_pulse = selected;
            OP_NOP: begin
               // No state changes; the result shows the current levels.
            end
            default: begin
            end
         endcase
      end

      bpwm_channel #(
         .COUNTER_WIDTH (COUNTER_WIDTH)
      ) u_channel (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .cmd       (cmd),
         .count     (count_next),
         .ramp_low  (ramp_low_ff),
         .ramp_high (ramp_high_ff),
         .level     (levels[gi])
      );
   end

   // Channels that are not built report a low level.
   for (genvar go = 0; go < 3; go++) begin : g_level_out
      if (go < CHANNEL_COUNT) begin : g_present
         assign levels_out[go] = levels[go];
      end else begin : g_absent
         assign levels_out[go] = 1'b0;
      end
   end

   assign rsp_data_in = {counter_wrap, levels_out};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

   // A wrapping tick leaves the counter at zero.
   `BPWM_ASSERT_NEXT(a_wrap_clears_count, clock, reset, accept && counter_wrap, count_q == '0)

   // A tick that does not wrap advances the counter by exactly one.
   `BPWM_ASSERT_NEXT(a_tick_advances, clock, reset, accept && is_tick && !counter_wrap, count_q == COUNTER_WIDTH'($past(count_q) + 1'b1))

   // Commands other than a tick never move the counter.
   `BPWM_ASSERT_NEXT(a_command_holds_count, clock, reset, accept && !is_tick, $stable(count_q))

   // Every accepted request shows up as a result carrying its wrap flag.
   `BPWM_ASSERT_NEXT(a_result_follows, clock, reset, accept, rsp_tvalid && (rsp_tdata[3] == $past(counter_wrap)))

   // A wrap can only be reported for a tick.
   `BPWM_ASSERT_SAME(a_wrap_only_on_tick, clock, reset, counter_wrap, is_tick)

endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bpwm_pkg::*;

   // Number of PWM channels in the block; channel code 3 addresses nothing.
   localparam int CHANNELS = 3;
   // Cycles without any accepted transaction before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   // Cycles allowed after the last result before the bus is considered idle.
   localparam int SETTLE_CYCLES = 3;
   localparam int REPORT_LIMIT = 10;

   // One result transaction: the three channel levels (channel 0 in bit 0) and
   // the wrap flag of the tick that produced it.
   typedef struct packed {
      logic       wrap;
      logic [2:0] level;
   } pwm_result_type;

   // One row of the directed stimulus. A row is either a register write or a
   // command; a command row may carry a hand-written expected result.
   typedef struct packed {
      bit                     is_write;
      logic [CSR_INDEX_W-1:0] sel;
      logic [CSR_W-1:0]       value;
      op_type                 op;
      logic [1:0]             ch;
      logic [DUTY_W-1:0]      duty;
      logic [PERIOD_W-1:0]    period;
      bit                     typed;
      logic [2:0]             levels;
      logic                   wrap;
   } plan_row_type;

   // One random phase: the register setting and how many commands are sent
   // under it.
   typedef struct packed {
      logic [15:0] reload;
      logic [15:0] low;
      logic [15:0] high;
      logic [15:0] items;
   } phase_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]       csr_wdata = '0;

   breathing_pwm_three_channel_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Mirror of the block state, kept in step with every accepted transaction.
   logic [15:0] counter_now;
   logic [15:0] compare_now [CHANNELS];
   logic        ramp_up [CHANNELS];
   logic        breathing [CHANNELS];
   logic [15:0] cfg_reload;
   logic [15:0] cfg_low;
   logic [15:0] cfg_high;

   // Results still owed by the block, oldest first.
   pwm_result_type levels_due [$];

   // Hand-written expectation for the command currently on the request bus.
   bit             row_typed = 1'b0;
   pwm_result_type row_expect = '0;

   // When set, neither side inserts idle cycles.
   bit calm = 1'b0;

   int idle_cycles = 0;
   int level_mismatches = 0;
   int commands_taken = 0;
   int results_checked = 0;
   int wraps_seen = 0;
   int ramp_steps = 0;
   int ramp_saturations = 0;

   // Computes the result of one command and advances the mirrored state. The
   // counter moves first on a tick, then every breathing channel whose compare
   // equals the new count takes one ramp step, and only then are the levels
   // formed from the updated compare values.
   function automatic pwm_result_type advance_pwm(input op_type op, input logic [1:0] ch,
                                                  input logic [DUTY_W-1:0] duty,
                                                  input logic [PERIOD_W-1:0] period);
      pwm_result_type res;
      logic [15:0]    c;
      int             i;
      res = '0;
      case (op)
         OP_TICK: begin
            // A counter left above a lowered top value wraps on the next tick.
            if (counter_now >= cfg_reload) begin
               counter_now = '0;
               res.wrap = 1'b1;
            end else begin
               counter_now = counter_now + 16'd1;
            end
            for (i = 0; i < CHANNELS; i++) begin
               if (breathing[i] && compare_now[i] == counter_now) begin
                  c = compare_now[i];
                  if (c < cfg_low) begin
                     ramp_up[i] = 1'b1;
                  end else if (c > cfg_high) begin
                     ramp_up[i] = 1'b0;
                  end
                  // The ramp saturates at both ends of the compare range.
                  if (ramp_up[i]) begin
                     if (c != 16'hFFFF) c = c + 16'd1;
                     else ramp_saturations++;
                  end else begin
                     if (c != 16'h0000) c = c - 16'd1;
                     else ramp_saturations++;
                  end
                  compare_now[i] = c;
                  ramp_steps++;
               end
            end
         end
         OP_DUTY: begin
            if (ch < CHANNELS) compare_now[ch] = {4'b0000, duty, 4'b0000};
         end
         OP_PULSE: begin
            // A pulse command leaves the ramp direction alone.
            if (ch < CHANNELS) begin
               if (period != '0) begin
                  compare_now[ch] = '0;
                  breathing[ch] = 1'b1;
               end else begin
                  breathing[ch] = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      for (i = 0; i < CHANNELS; i++) res.level[i] = counter_now < compare_now[i];
      return res;
   endfunction

   function automatic void report_mismatch(input string what, input pwm_result_type want,
                                           input pwm_result_type got);
      if (level_mismatches < REPORT_LIMIT) begin
         $display("[%0t] mismatch on %s: expected levels %b wrap %b, got levels %b wrap %b",
                  $realtime, what, want.level, want.wrap, got.level, got.wrap);
      end
      level_mismatches++;
   endfunction

   // Draws the idle cycles one side inserts ahead of its next transaction.
   function automatic int pause_length();
      if (calm || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   // Everything that happens at a rising edge is observed here: register
   // writes, accepted commands (predicted and queued) and accepted results
   // (checked field by field against the oldest expectation).
   always @(posedge clock) begin
      pwm_result_type got;
      pwm_result_type want;
      pwm_result_type predicted;
      int             i;
      if (reset) begin
         counter_now = '0;
         for (i = 0; i < CHANNELS; i++) begin
            compare_now[i] = '0;
            ramp_up[i] = 1'b1;
            breathing[i] = 1'b0;
         end
         cfg_reload = AUTO_RELOAD_RESET;
         cfg_low = RAMP_LOW_RESET;
         cfg_high = RAMP_HIGH_RESET;
         levels_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_AUTO_RELOAD: cfg_reload = csr_wdata;
               CSR_RAMP_LOW:    cfg_low = csr_wdata;
               CSR_RAMP_HIGH:   cfg_high = csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            predicted = advance_pwm(op_type'(req_tuser), req_tdata[1:0], req_tdata[9:2],
                                    req_tdata[17:10]);
            levels_due.push_back(row_typed ? row_expect : predicted);
            commands_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.level = rsp_tdata[2:0];
            got.wrap = rsp_tdata[3];
            if (levels_due.size() == 0) begin
               report_mismatch("result with no command outstanding", '0, got);
            end else begin
               want = levels_due.pop_front();
               for (i = 0; i < CHANNELS; i++) begin
                  if (got.level[i] !== want.level[i]) begin
                     report_mismatch($sformatf("level of channel %0d", i), want, got);
                  end
               end
               if (got.wrap !== want.wrap) report_mismatch("period wrap flag", want, got);
               if (want.wrap) wraps_seen++;
               results_checked++;
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   // The receiver: before every result it may hold rsp_tready low for a while,
   // then keeps it high until a result transaction completes.
   initial begin
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = pause_length();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Sends one command and returns at the falling edge after it was taken.
   // The valid stays high into the next call when no gap is drawn, so a
   // back-to-back stream never lowers and raises it in the same step.
   task automatic send_command(input op_type op, input logic [1:0] ch,
                               input logic [DUTY_W-1:0] duty,
                               input logic [PERIOD_W-1:0] period,
                               input bit typed, input pwm_result_type typed_value);
      int gap;
      gap = pause_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_typed = typed;
      row_expect = typed_value;
      req_tdata <= {6'b000000, period, duty, ch};
      req_tuser <= op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stops sending and waits until every owed result has come back, then for a
   // settling margin, so the block is idle for a register write.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (levels_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] sel,
                                 input logic [CSR_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Directed part, run from the reset setting. Rows with a typed result can be
   // checked by hand; the remaining rows are left to the predictor.
   plan_row_type directed_plan [26] = '{
      // Quiet block after reset, then the first tick.
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_NOP,   2'd0, 8'd0,   8'd0,   1'b1, 3'b000, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_TICK,  2'd0, 8'd0,   8'd0,   1'b1, 3'b000, 1'b0},
      // Duty extremes, and commands to the unused channel code.
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_DUTY,  2'd0, 8'd255, 8'd0,   1'b1, 3'b001, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_DUTY,  2'd1, 8'd0,   8'd0,   1'b1, 3'b001, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_DUTY,  2'd2, 8'd1,   8'd0,   1'b1, 3'b101, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_DUTY,  2'd3, 8'd255, 8'd0,   1'b1, 3'b101, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_PULSE, 2'd3, 8'd0,   8'd255, 1'b1, 3'b101, 1'b0},
      // Breathing on for channels 1 and 2, then off again for channel 2.
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_PULSE, 2'd1, 8'd0,   8'd1,   1'b1, 3'b101, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_PULSE, 2'd2, 8'd0,   8'd255, 1'b1, 3'b001, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_PULSE, 2'd2, 8'd0,   8'd0,   1'b1, 3'b001, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_NOP,   2'd3, 8'hAA,  8'h55,  1'b1, 3'b001, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_TICK,  2'd0, 8'd0,   8'd0,   1'b1, 3'b001, 1'b0},
      // Short period: the second tick wraps and channel 1 takes a ramp step.
      '{1'b1, CSR_AUTO_RELOAD, 16'd3, OP_NOP,   2'd0, 8'd0,   8'd0,   1'b0, 3'b000, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_TICK,  2'd0, 8'd0,   8'd0,   1'b1, 3'b001, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_TICK,  2'd0, 8'd0,   8'd0,   1'b1, 3'b011, 1'b1},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_TICK,  2'd0, 8'd0,   8'd0,   1'b0, 3'b000, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_TICK,  2'd0, 8'd0,   8'd0,   1'b0, 3'b000, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_TICK,  2'd0, 8'd0,   8'd0,   1'b0, 3'b000, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_PULSE, 2'd0, 8'd0,   8'h80,  1'b0, 3'b000, 1'b0},
      // Ramp limits at zero, then a top value below the current count.
      '{1'b1, CSR_RAMP_LOW,    16'd0, OP_NOP,   2'd0, 8'd0,   8'd0,   1'b0, 3'b000, 1'b0},
      '{1'b1, CSR_RAMP_HIGH,   16'd0, OP_NOP,   2'd0, 8'd0,   8'd0,   1'b0, 3'b000, 1'b0},
      '{1'b1, CSR_AUTO_RELOAD, 16'd0, OP_NOP,   2'd0, 8'd0,   8'd0,   1'b0, 3'b000, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_TICK,  2'd0, 8'd0,   8'd0,   1'b0, 3'b000, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_TICK,  2'd0, 8'd0,   8'd0,   1'b0, 3'b000, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_DUTY,  2'd2, 8'hFF,  8'd0,   1'b0, 3'b000, 1'b0},
      '{1'b0, CSR_AUTO_RELOAD, 16'd0, OP_TICK,  2'd0, 8'd0,   8'd0,   1'b0, 3'b000, 1'b0}
   };

   // Random phases. Short periods keep wraps and compare matches frequent; the
   // extremes of all three registers are set jointly in two phases, and a long
   // period is followed by a short one so the count is left above the new top.
   phase_type phase_plan [9] = '{
      '{16'd4079,  16'd2,     16'd3818,  16'd60},
      '{16'd15,    16'd2,     16'd12,    16'd150},
      '{16'd255,   16'd20,    16'd200,   16'd150},
      '{16'd7,     16'd0,     16'd5,     16'd150},
      '{16'd0,     16'd0,     16'd0,     16'd60},
      '{16'd65535, 16'd65535, 16'd65535, 16'd60},
      '{16'd31,    16'd65535, 16'd0,     16'd100},
      '{16'd40,    16'd0,     16'd65535, 16'd100},
      '{16'd12,    16'd3,     16'd9,     16'd70}
   };

   // Ends the run when nothing has been accepted for too long.
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin
      op_type              op;
      logic [1:0]          ch;
      logic [DUTY_W-1:0]   duty;
      logic [PERIOD_W-1:0] period;
      pwm_result_type      typed_value;
      int                  done;
      int                  pick;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[r]) begin
         if (directed_plan[r].is_write) begin
            settle();
            write_register(directed_plan[r].sel, directed_plan[r].value);
         end else begin
            typed_value.level = directed_plan[r].levels;
            typed_value.wrap = directed_plan[r].wrap;
            send_command(directed_plan[r].op, directed_plan[r].ch, directed_plan[r].duty,
                         directed_plan[r].period, directed_plan[r].typed, typed_value);
         end
      end

      foreach (phase_plan[p]) begin
         // Every phase starts from an idle block; some run with no idling at all.
         settle();
         calm = (p % 3 == 1);
         write_register(CSR_AUTO_RELOAD, phase_plan[p].reload);
         write_register(CSR_RAMP_LOW, phase_plan[p].low);
         write_register(CSR_RAMP_HIGH, phase_plan[p].high);
         done = 0;
         while (done < phase_plan[p].items) begin
            // Mostly ticks, since the ramps only move on compare matches.
            pick = $urandom_range(0, 99);
            if (pick < 70) op = OP_TICK;
            else if (pick < 80) op = OP_DUTY;
            else if (pick < 90) op = OP_PULSE;
            else op = OP_NOP;
            ch = 2'($urandom_range(0, 3));
            // Small duty bytes land inside the short periods used here.
            duty = ($urandom_range(0, 3) != 0) ? DUTY_W'($urandom_range(0, 255))
                                                : DUTY_W'($urandom_range(0, 4));
            period = ($urandom_range(0, 2) == 0) ? 8'd0 : PERIOD_W'($urandom_range(1, 255));
            send_command(op, ch, duty, period, 1'b0, '0);
            done++;
         end
      end

      settle();
      calm = 1'b0;
      repeat (4) @(posedge clock);
      if (levels_due.size() != 0) begin
         $display("%0d results never arrived", levels_due.size());
         level_mismatches++;
      end
      $display("Covered %0d commands and %0d checked results over %0d register settings.",
               commands_taken, results_checked, $size(phase_plan) + 1);
      $display("Saw %0d counter wraps, %0d ramp steps and %0d saturated ramp steps.",
               wraps_seen, ramp_steps, ramp_saturations);
      if (level_mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches in total", level_mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
